// File: hw/rtl/mwma_pkg.sv
// Shared types and constants for the multi-window moving average.
// Depends on nothing; every other file except mwma_ram refers to it by scoped names.
`default_nettype none

package mwma_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SUM_W     = 23;
	localparam int NUM_WIN   = 7;
	localparam int WIN_IDX_W = 3;
	localparam int WIN_LEN_W = 7;

	// Reciprocal scale: floor(x / N) = (x * ceil(2^30 / N)) >> 30 is exact
	// for x < 2^23 and N <= 128.
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 30;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef logic [SAMPLE_W-1:0]  sample_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [WIN_IDX_W-1:0] win_idx_t;
	typedef logic [WIN_LEN_W-1:0] win_len_t;
	typedef logic [RECIP_W-1:0]   recip_t;
	typedef logic [PROD_W-1:0]    prod_t;

	localparam win_idx_t LAST_WIN = win_idx_t'(NUM_WIN - 1);

	// Window lengths, shortest first
	localparam win_len_t WIN_LEN [NUM_WIN] = '{
		7'd2, 7'd4, 7'd8, 7'd12, 7'd25, 7'd60, 7'd125
	};

	// ceil(2^30 / N) for each window
	localparam recip_t WIN_RECIP [NUM_WIN] = '{
		30'd536870912, 30'd268435456, 30'd134217728, 30'd89478486,
		30'd42949673,  30'd17895698,  30'd8589935
	};

	// Tag that travels with a window sum through the divider
	typedef struct packed {
		logic     valid;
		win_idx_t win;
	} win_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/mwma_if.sv
// Valid/ready channel interfaces for samples in and averages out.
// Depends on mwma_pkg for the field types.
`default_nettype none

interface mwma_in_if;
	logic              valid;
	logic              ready;
	mwma_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mwma_out_if;
	logic              valid;
	logic              ready;
	mwma_pkg::sample_t avg_2;
	mwma_pkg::sample_t avg_4;
	mwma_pkg::sample_t avg_8;
	mwma_pkg::sample_t avg_12;
	mwma_pkg::sample_t avg_25;
	mwma_pkg::sample_t avg_60;
	mwma_pkg::sample_t avg_125;

	modport source (output valid, output avg_2, output avg_4, output avg_8,
		output avg_12, output avg_25, output avg_60, output avg_125, input ready);
	modport sink (input valid, input avg_2, input avg_4, input avg_8,
		input avg_12, input avg_25, input avg_60, input avg_125, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mwma_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module mwma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/mwma_div.sv
// Constant divider: window sum divided by its window length via a
// registered reciprocal multiply. Depends on mwma_pkg.
`default_nettype none

module mwma_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mwma_pkg::win_tag_t tag_in,
	input  wire mwma_pkg::sum_t     sum_in,
	output mwma_pkg::win_tag_t      tag_out,
	output mwma_pkg::sample_t       quot
);

	mwma_pkg::recip_t recip;
	mwma_pkg::prod_t  prod_s3;
	mwma_pkg::sum_t   q_full;

	// Reciprocal for the window being divided
	assign recip = mwma_pkg::WIN_RECIP[tag_in.win];

	// Tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_s3 <= mwma_pkg::prod_t'(sum_in) * mwma_pkg::prod_t'(recip);
	end

	assign q_full = prod_s3[mwma_pkg::PROD_W-1:mwma_pkg::RECIP_SHIFT];
	assign quot   = q_full[mwma_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/multi_window_moving_average.sv
// Multi-window moving average: each 16-bit sample yields the floor means of
// the newest 2, 4, 8, 12, 25, 60 and 125 samples. Depends on mwma_pkg,
// mwma_if, mwma_ram and mwma_div.
//
// Usage: after reset the block clears every slot of the sample history and
// holds samples.ready low meanwhile. The accepting cycle writes the sample
// into the history RAM; its result then reaches the output register: one read
// per window fetches the sample leaving that window through the RAM's single
// port, a three-stage tail (running-sum update, reciprocal multiply, result
// capture) drains, and the done state loads the output register. A sample
// occupies the block from acceptance until then, so no new sample is taken
// while one is in flight. A new sample is taken once the previous result has
// moved into the output register, so one result may wait on averages.ready
// while the next sample is already accepted. Unwritten history counts as
// zero; the divisor is always the full window length.
`default_nettype none

module multi_window_moving_average #(
	parameter int HISTORY_DEPTH = 128
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mwma_in_if.sink    samples,
	mwma_out_if.source averages
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW:0]   DEPTH_V = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      slot_q;
	logic [AW-1:0]      next_slot;
	logic [AW-1:0]      rd_addr;
	logic [AW:0]        back_sum;
	logic [AW:0]        back_wrap;
	mwma_pkg::win_idx_t rd_win_q;
	mwma_pkg::sample_t  sample_q;
	mwma_pkg::sum_t     sums_q [mwma_pkg::NUM_WIN];
	mwma_pkg::sum_t     new_sum;
	mwma_pkg::sum_t     sum_s2;
	mwma_pkg::win_tag_t tag_s1;
	mwma_pkg::win_tag_t tag_s2;
	mwma_pkg::win_tag_t tag_s3;
	mwma_pkg::sample_t  quot;
	mwma_pkg::sample_t  work_q [mwma_pkg::NUM_WIN];
	mwma_pkg::sample_t  out_q [mwma_pkg::NUM_WIN];
	logic               out_valid_q;
	logic               accept;
	logic               out_free;
	logic               clearing;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	mwma_pkg::sample_t  ram_wdata;
	mwma_pkg::sample_t  ram_rdata;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign clearing      = (state_q == ST_CLEAR);
	assign out_free      = !out_valid_q || averages.ready;

	// Ring slot advance
	assign next_slot = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;

	// Slot of the sample leaving the current window
	assign back_sum  = {1'b0, slot_q} + DEPTH_V
		- (AW+1)'(mwma_pkg::WIN_LEN[rd_win_q]);
	assign back_wrap = (back_sum >= DEPTH_V) ? back_sum - DEPTH_V : back_sum;
	assign rd_addr   = back_wrap[AW-1:0];

	// History RAM port sharing: clear sweep, sample write, leaving-sample reads
	always_comb begin
		ram_we    = clearing || accept;
		ram_wdata = clearing ? '0 : samples.sample;
		if (clearing) begin
			ram_addr = clr_q;
		end else if (accept) begin
			ram_addr = next_slot;
		end else begin
			ram_addr = rd_addr;
		end
	end

	mwma_ram #(
		.WIDTH(mwma_pkg::SAMPLE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			slot_q   <= '0;
			rd_win_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						slot_q   <= next_slot;
						rd_win_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_win_q <= rd_win_q + 1'b1;
					if (rd_win_q == mwma_pkg::LAST_WIN) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s3.valid && tag_s3.win == mwma_pkg::LAST_WIN) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Sample hold for the running-sum update
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.sample;
		end
	end

	// Read-issue tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= '{valid: (state_q == ST_READ), win: rd_win_q};
			tag_s2 <= tag_s1;
		end
	end

	// Running sums: add the new sample, drop the leaving one
	assign new_sum = sums_q[tag_s1.win] + mwma_pkg::sum_t'(sample_q)
		- mwma_pkg::sum_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mwma_pkg::NUM_WIN; i++) begin
				sums_q[i] <= '0;
			end
		end else if (tag_s1.valid) begin
			sums_q[tag_s1.win] <= new_sum;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= new_sum;
	end

	mwma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_in (tag_s2),
		.sum_in (sum_s2),
		.tag_out(tag_s3),
		.quot   (quot)
	);

	// Collect averages as they come out of the divider
	always_ff @(posedge clk) begin
		if (tag_s3.valid) begin
			work_q[tag_s3.win] <= quot;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= work_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (averages.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign averages.valid   = out_valid_q;
	assign averages.avg_2   = out_q[0];
	assign averages.avg_4   = out_q[1];
	assign averages.avg_8   = out_q[2];
	assign averages.avg_12  = out_q[3];
	assign averages.avg_25  = out_q[4];
	assign averages.avg_60  = out_q[5];
	assign averages.avg_125 = out_q[6];

endmodule

`default_nettype wire
